FILE: sv/pictp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pictp_pkg
// Shared sizes, codes and record types of the point-in-convex-parts test.
// ----------------------------------------------------------------------------
package pictp_pkg;

    localparam int MAX_FACES = 64;
    localparam int ADDR_W    = $clog2(MAX_FACES);
    localparam int FC_W      = $clog2(MAX_FACES + 1);

    // Depth cap of 9999.0 in the Q22.30 format of plane depths.
    localparam logic signed [51:0] DEPTH_CAP = 52'(64'd9999 << 30);

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef enum logic [2:0] {
        REG_SPHERE_MODE = 3'd0,
        REG_RADIUS      = 3'd1,
        REG_CENTER_X    = 3'd2,
        REG_CENTER_Y    = 3'd3,
        REG_CENTER_Z    = 3'd4,
        REG_OFFSET_X    = 3'd5,
        REG_OFFSET_Y    = 3'd6,
        REG_OFFSET_Z    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        fric;
        logic               pe;
    } face_t;

    typedef struct packed {
        logic               hit;
        logic [30:0]        depth;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic [15:0]        fric;
        logic               fvalid;
    } res_t;

    typedef struct packed {
        logic done;
        logic walk;
    } sph_stat_t;

endpackage
`default_nettype wire

FILE: sv/pictp_ifs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pictp_ifs
// Request and response channels of the point-in-convex-parts test.
// ----------------------------------------------------------------------------
interface pictp_req_if;
    logic               valid;
    logic               ready;
    logic               opcode;
    logic [5:0]         entry_index;
    logic signed [31:0] coord_x;
    logic signed [31:0] coord_y;
    logic signed [31:0] coord_z;
    logic signed [15:0] normal_in_x;
    logic signed [15:0] normal_in_y;
    logic signed [15:0] normal_in_z;
    logic [15:0]        friction_in;
    logic               part_end;
    logic               table_end;

    modport source (output valid, opcode, entry_index, coord_x, coord_y, coord_z,
                    normal_in_x, normal_in_y, normal_in_z, friction_in, part_end,
                    table_end, input ready);
    modport sink (input valid, opcode, entry_index, coord_x, coord_y, coord_z,
                  normal_in_x, normal_in_y, normal_in_z, friction_in, part_end,
                  table_end, output ready);
endinterface

interface pictp_rsp_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic [30:0]        depth;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic [15:0]        friction;
    logic               friction_valid;

    modport source (output valid, hit, depth, normal_x, normal_y, normal_z, friction,
                    friction_valid, input ready);
    modport sink (input valid, hit, depth, normal_x, normal_y, normal_z, friction,
                  friction_valid, output ready);
endinterface
`default_nettype wire

FILE: sv/pictp_face_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pictp_face_ram
// Face table: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pictp_face_ram
    import pictp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire face_t             wdata,
    input  wire logic [ADDR_W-1:0] raddr,
    output face_t                  rdata
);

    face_t mem [MAX_FACES];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: sv/pictp_sphere.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pictp_sphere
// Bounding sphere test, with square root and normalising divide for sphere mode.
// ----------------------------------------------------------------------------
module pictp_sphere
    import pictp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               mode,
    input  wire logic signed [31:0] px,
    input  wire logic signed [31:0] py,
    input  wire logic signed [31:0] pz,
    input  wire logic signed [31:0] cx,
    input  wire logic signed [31:0] cy,
    input  wire logic signed [31:0] cz,
    input  wire logic [30:0]        radius,
    output logic                    busy,
    output sph_stat_t               stat,
    output res_t                    res
);

    typedef enum logic [2:0] {SP_IDLE, SP_SQ, SP_CMP, SP_ROOT, SP_PREP, SP_DIV,
                              SP_FIN} sp_state_t;

    sp_state_t          state_reg;
    logic signed [32:0] dx_reg, dy_reg, dz_reg;
    logic [30:0]        ax_reg, ay_reg, az_reg;
    logic [61:0]        sqx_reg, sqy_reg, sqz_reg, rr_reg;
    logic               rng_reg;
    logic [63:0]        x_reg, root_reg, bit_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        len_reg;
    logic [32:0]        remx_reg, remy_reg, remz_reg;
    logic [14:0]        qx_reg, qy_reg, qz_reg;

    logic [32:0] absx, absy, absz;
    logic [63:0] sum, trial;
    logic        gex, gey, gez;
    logic [32:0] r2x, r2y, r2z;

    always_comb
    begin
        absx  = dx_reg[32] ? 33'(-dx_reg) : 33'(dx_reg);
        absy  = dy_reg[32] ? 33'(-dy_reg) : 33'(dy_reg);
        absz  = dz_reg[32] ? 33'(-dz_reg) : 33'(dz_reg);
        sum   = 64'(sqx_reg) + 64'(sqy_reg) + 64'(sqz_reg);
        trial = root_reg + bit_reg;
        gex   = remx_reg >= {1'b0, len_reg};
        gey   = remy_reg >= {1'b0, len_reg};
        gez   = remz_reg >= {1'b0, len_reg};
        r2x   = gex ? remx_reg - {1'b0, len_reg} : remx_reg;
        r2y   = gey ? remy_reg - {1'b0, len_reg} : remy_reg;
        r2z   = gez ? remz_reg - {1'b0, len_reg} : remz_reg;
    end

    assign busy = (state_reg != SP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SP_IDLE;
            stat      <= '0;
        end
        else
        begin
            stat <= '0;
            case (state_reg)
                SP_IDLE:
                begin
                    if (start)
                    begin
                        dx_reg    <= 33'(px) - 33'(cx);
                        dy_reg    <= 33'(py) - 33'(cy);
                        dz_reg    <= 33'(pz) - 33'(cz);
                        state_reg <= SP_SQ;
                    end
                end
                SP_SQ:
                begin
                    ax_reg    <= absx[30:0];
                    ay_reg    <= absy[30:0];
                    az_reg    <= absz[30:0];
                    rng_reg   <= (absx[32:31] == 2'b00) && (absy[32:31] == 2'b00) &&
                                 (absz[32:31] == 2'b00);
                    sqx_reg   <= absx[30:0] * absx[30:0];
                    sqy_reg   <= absy[30:0] * absy[30:0];
                    sqz_reg   <= absz[30:0] * absz[30:0];
                    rr_reg    <= radius * radius;
                    state_reg <= SP_CMP;
                end
                SP_CMP:
                begin
                    res <= '0;
                    if (!(rng_reg && (sum <= 64'(rr_reg))))
                    begin
                        stat.done <= 1'b1;
                        state_reg <= SP_IDLE;
                    end
                    else if (!mode)
                    begin
                        stat.done <= 1'b1;
                        stat.walk <= 1'b1;
                        state_reg <= SP_IDLE;
                    end
                    else
                    begin
                        x_reg     <= sum;
                        root_reg  <= '0;
                        bit_reg   <= 64'(1) << 62;
                        cnt_reg   <= '0;
                        state_reg <= SP_ROOT;
                    end
                end
                SP_ROOT:
                begin
                    if (x_reg >= trial)
                    begin
                        x_reg    <= x_reg - trial;
                        root_reg <= (root_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        root_reg <= root_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= SP_PREP;
                    end
                end
                SP_PREP:
                begin
                    len_reg   <= root_reg[31:0];
                    remx_reg  <= {2'b00, ax_reg};
                    remy_reg  <= {2'b00, ay_reg};
                    remz_reg  <= {2'b00, az_reg};
                    qx_reg    <= '0;
                    qy_reg    <= '0;
                    qz_reg    <= '0;
                    cnt_reg   <= '0;
                    // A point at the centre keeps a zero normal.
                    state_reg <= (root_reg[31:0] == 32'd0) ? SP_FIN : SP_DIV;
                end
                SP_DIV:
                begin
                    remx_reg <= {r2x[31:0], 1'b0};
                    remy_reg <= {r2y[31:0], 1'b0};
                    remz_reg <= {r2z[31:0], 1'b0};
                    qx_reg   <= {qx_reg[13:0], gex};
                    qy_reg   <= {qy_reg[13:0], gey};
                    qz_reg   <= {qz_reg[13:0], gez};
                    cnt_reg  <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd14)
                    begin
                        state_reg <= SP_FIN;
                    end
                end
                SP_FIN:
                begin
                    res.hit    <= 1'b1;
                    res.depth  <= radius - len_reg[30:0];
                    res.nx     <= dx_reg[32] ? -{1'b0, qx_reg} : {1'b0, qx_reg};
                    res.ny     <= dy_reg[32] ? -{1'b0, qy_reg} : {1'b0, qy_reg};
                    res.nz     <= dz_reg[32] ? -{1'b0, qz_reg} : {1'b0, qz_reg};
                    res.fric   <= '0;
                    res.fvalid <= 1'b0;
                    stat.done  <= 1'b1;
                    state_reg  <= SP_IDLE;
                end
                default:
                begin
                    state_reg <= SP_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

FILE: sv/pictp_walk.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pictp_walk
// Walks the face table one face per cycle and finds the first enclosing part.
// ----------------------------------------------------------------------------
module pictp_walk
    import pictp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic signed [31:0] px,
    input  wire logic signed [31:0] py,
    input  wire logic signed [31:0] pz,
    input  wire logic signed [31:0] ox,
    input  wire logic signed [31:0] oy,
    input  wire logic signed [31:0] oz,
    input  wire logic [FC_W-1:0]    fc,
    output logic [ADDR_W-1:0]       raddr,
    input  wire face_t              rdata,
    output logic                    busy,
    output logic                    done,
    output res_t                    res
);

    logic [FC_W-1:0]    addr_reg;
    logic               issue_reg;
    logic               v1_reg, v2_reg, v3_reg;
    logic               last1_reg, last2_reg, last3_reg;
    logic signed [33:0] qx_reg, qy_reg, qz_reg;
    logic signed [15:0] n2x_reg, n2y_reg, n2z_reg, n3x_reg, n3y_reg, n3z_reg;
    logic [15:0]        f2_reg, f3_reg;
    logic               pe2_reg, pe3_reg;
    logic signed [49:0] mx_reg, my_reg, mz_reg;
    logic signed [51:0] least_reg;
    logic [47:0]        best_reg;
    logic               failed_reg, fresh_reg;

    logic signed [51:0] d;
    logic signed [51:0] l;
    logic [47:0]        bn;
    logic               fr;
    logic [FC_W-1:0]    fc_m1;

    assign raddr = addr_reg[ADDR_W-1:0];
    assign fc_m1 = fc - FC_W'(1);
    assign busy  = issue_reg || v1_reg || v2_reg || v3_reg;

    // Plane depth of the face in stage three and the part state it leaves.
    always_comb
    begin
        d  = -(52'(mx_reg) + 52'(my_reg) + 52'(mz_reg));
        l  = least_reg;
        bn = fresh_reg ? {n3x_reg, n3y_reg, n3z_reg} : best_reg;
        fr = failed_reg;
        if (!fr)
        begin
            if (d > 52'sd0)
            begin
                if (d < l)
                begin
                    l  = d;
                    bn = {n3x_reg, n3y_reg, n3z_reg};
                end
            end
            else
            begin
                fr = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                addr_reg   <= '0;
                least_reg  <= DEPTH_CAP;
                failed_reg <= 1'b0;
                fresh_reg  <= 1'b1;
                res        <= '0;
                if (fc == '0)
                begin
                    done <= 1'b1;
                end
                else
                begin
                    issue_reg <= 1'b1;
                end
            end
            else
            begin
                if (issue_reg)
                begin
                    addr_reg  <= addr_reg + FC_W'(1);
                    last1_reg <= (addr_reg == fc_m1);
                    if (addr_reg == fc_m1)
                    begin
                        issue_reg <= 1'b0;
                    end
                end
                v1_reg <= issue_reg;

                v2_reg    <= v1_reg;
                last2_reg <= last1_reg;
                qx_reg    <= 34'(px) - (34'(rdata.ax) + 34'(ox));
                qy_reg    <= 34'(py) - (34'(rdata.ay) + 34'(oy));
                qz_reg    <= 34'(pz) - (34'(rdata.az) + 34'(oz));
                n2x_reg   <= rdata.nx;
                n2y_reg   <= rdata.ny;
                n2z_reg   <= rdata.nz;
                f2_reg    <= rdata.fric;
                pe2_reg   <= rdata.pe;

                v3_reg    <= v2_reg;
                last3_reg <= last2_reg;
                mx_reg    <= n2x_reg * qx_reg;
                my_reg    <= n2y_reg * qy_reg;
                mz_reg    <= n2z_reg * qz_reg;
                n3x_reg   <= n2x_reg;
                n3y_reg   <= n2y_reg;
                n3z_reg   <= n2z_reg;
                f3_reg    <= f2_reg;
                pe3_reg   <= pe2_reg;

                if (v3_reg)
                begin
                    least_reg  <= l;
                    best_reg   <= bn;
                    failed_reg <= fr;
                    fresh_reg  <= 1'b0;
                    if (pe3_reg || last3_reg)
                    begin
                        if (!fr)
                        begin
                            res.hit    <= 1'b1;
                            res.depth  <= l[44:14];
                            res.nx     <= bn[47:32];
                            res.ny     <= bn[31:16];
                            res.nz     <= bn[15:0];
                            res.fric   <= f3_reg;
                            res.fvalid <= 1'b1;
                            done       <= 1'b1;
                            issue_reg  <= 1'b0;
                            v1_reg     <= 1'b0;
                            v2_reg     <= 1'b0;
                            v3_reg     <= 1'b0;
                        end
                        else
                        begin
                            // A rejected part leaves nothing for the next one.
                            least_reg  <= DEPTH_CAP;
                            failed_reg <= 1'b0;
                            fresh_reg  <= 1'b1;
                            if (last3_reg)
                            begin
                                done <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule
`default_nettype wire

FILE: sv/point_in_convex_parts_test_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// point_in_convex_parts_test_top
// Point test against a bounding sphere and a table of convex parts.
// ----------------------------------------------------------------------------
// A load item writes one face entry and gives no result. A test item gives
// one result: a sphere miss ends at the sphere test; on a sphere hit, sphere
// mode goes on to the square root, which resolves one bit a cycle, and the
// divider, which gives one quotient bit a cycle, and face mode goes on to a
// face walk that reads one face per cycle from the face memory port up to
// the enclosing part, in a table of up to 64 faces. The result is then
// registered in the output register once that is free; loads are taken
// while a result waits there.
module point_in_convex_parts_test_top
    import pictp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    pictp_req_if.sink        req,
    pictp_rsp_if.source      rsp,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_index,
    input  wire logic [31:0] wr_data
);

    typedef enum logic [1:0] {T_IDLE, T_SPH, T_WALK, T_OUT} t_state_t;

    t_state_t           state_reg;
    logic               mode_reg;
    logic [30:0]        radius_reg;
    logic signed [31:0] cx_reg, cy_reg, cz_reg, ox_reg, oy_reg, oz_reg;
    logic [FC_W-1:0]    fc_reg;
    logic signed [31:0] px_reg, py_reg, pz_reg;
    res_t               res_reg;
    res_t               out_reg;
    logic               out_valid_reg;

    logic               accept, load_we, test_start, idx_ok;
    logic [31:0]        idx_wide;
    face_t              wface, rface;
    logic [ADDR_W-1:0]  raddr;
    logic               sph_busy, walk_busy, walk_done;
    sph_stat_t          sph_stat;
    res_t               sph_res, walk_res;

    assign req.ready  = (state_reg == T_IDLE);
    assign accept     = req.valid && req.ready;
    assign idx_wide   = 32'(req.entry_index);
    assign idx_ok     = idx_wide < 32'(MAX_FACES);
    assign load_we    = accept && (req.opcode == OP_LOAD) && idx_ok;
    assign test_start = accept && (req.opcode == OP_TEST);

    assign wface.ax   = req.coord_x;
    assign wface.ay   = req.coord_y;
    assign wface.az   = req.coord_z;
    assign wface.nx   = req.normal_in_x;
    assign wface.ny   = req.normal_in_y;
    assign wface.nz   = req.normal_in_z;
    assign wface.fric = req.friction_in;
    assign wface.pe   = req.part_end;

    pictp_face_ram u_ram (
        .clk   (clk),
        .we    (load_we),
        .waddr (idx_wide[ADDR_W-1:0]),
        .wdata (wface),
        .raddr (raddr),
        .rdata (rface)
    );

    pictp_sphere u_sphere (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (test_start),
        .mode   (mode_reg),
        .px     (req.coord_x),
        .py     (req.coord_y),
        .pz     (req.coord_z),
        .cx     (cx_reg),
        .cy     (cy_reg),
        .cz     (cz_reg),
        .radius (radius_reg),
        .busy   (sph_busy),
        .stat   (sph_stat),
        .res    (sph_res)
    );

    pictp_walk u_walk (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sph_stat.done && sph_stat.walk),
        .px    (px_reg),
        .py    (py_reg),
        .pz    (pz_reg),
        .ox    (ox_reg),
        .oy    (oy_reg),
        .oz    (oz_reg),
        .fc    (fc_reg),
        .raddr (raddr),
        .rdata (rface),
        .busy  (walk_busy),
        .done  (walk_done),
        .res   (walk_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 1'b0;
            radius_reg <= '0;
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            ox_reg     <= '0;
            oy_reg     <= '0;
            oz_reg     <= '0;
        end
        else if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_SPHERE_MODE: mode_reg   <= wr_data[0];
                REG_RADIUS:      radius_reg <= wr_data[30:0];
                REG_CENTER_X:    cx_reg     <= wr_data;
                REG_CENTER_Y:    cy_reg     <= wr_data;
                REG_CENTER_Z:    cz_reg     <= wr_data;
                REG_OFFSET_X:    ox_reg     <= wr_data;
                REG_OFFSET_Y:    oy_reg     <= wr_data;
                REG_OFFSET_Z:    oz_reg     <= wr_data;
                default:         mode_reg   <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            fc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                T_IDLE:
                begin
                    if (load_we && req.table_end)
                    begin
                        fc_reg <= FC_W'(idx_wide + 32'd1);
                    end
                    if (test_start)
                    begin
                        px_reg    <= req.coord_x;
                        py_reg    <= req.coord_y;
                        pz_reg    <= req.coord_z;
                        state_reg <= T_SPH;
                    end
                end
                T_SPH:
                begin
                    if (sph_stat.done)
                    begin
                        res_reg   <= sph_res;
                        state_reg <= sph_stat.walk ? T_WALK : T_OUT;
                    end
                end
                T_WALK:
                begin
                    if (walk_done)
                    begin
                        res_reg   <= walk_res;
                        state_reg <= T_OUT;
                    end
                end
                T_OUT:
                begin
                    if (!out_valid_reg || rsp.ready)
                    begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= T_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.hit            = out_reg.hit;
    assign rsp.depth          = out_reg.depth;
    assign rsp.normal_x       = out_reg.nx;
    assign rsp.normal_y       = out_reg.ny;
    assign rsp.normal_z       = out_reg.nz;
    assign rsp.friction       = out_reg.fric;
    assign rsp.friction_valid = out_reg.fvalid;

`ifndef SYNTH
    a_test_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready && req.opcode == OP_TEST) |=> !req.ready)
        else $error("request taken while a test item is in progress");

    a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
        !(sph_busy && walk_busy))
        else $error("sphere unit and face walk active together");

    a_walk_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        walk_done |-> (state_reg == T_WALK))
        else $error("face walk finished outside the walk state");
`endif

endmodule
`default_nettype wire
